>>> rtl/core/planar_tensor_minmax_to_bgr8_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min-max stretch unit
// Each macro wraps one concurrent assertion with a clock and a reset; the
// bodies are left empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PLANAR_TENSOR_MINMAX_TO_BGR8_UNIT_DEFINES_SVH
`define PLANAR_TENSOR_MINMAX_TO_BGR8_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define PTMM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define PTMM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PTMM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PTMM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/ptmm_pkg.sv
// ----------------------------------------------------------------------------
// ptmm_pkg
// Shared types and constants of the min-max stretch to BGR byte unit.
// ----------------------------------------------------------------------------
package ptmm_pkg;

   // Default frame store geometry.
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // Field widths.
   localparam int VAL_W      = 24;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   // Value 1.0 in Q8.16 and the signed 24-bit extremes.
   localparam logic signed [VAL_W-1:0] Q_ONE   = 24'sd65536;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

   // Request codes.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TENSOR_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TENSOR_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_COLUMNS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_ROWS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_ENABLE   = 3'd4;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] RST_SIZE = 9'd256;

   // Control sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CONV,
      ST_OUT,
      ST_SYNC
   } state_type;

   // One stored pixel.
   typedef struct packed {
      logic signed [VAL_W-1:0] red;
      logic signed [VAL_W-1:0] green;
      logic signed [VAL_W-1:0] blue;
   } pixel_type;

   // Frame range handed to each conversion lane.
   typedef struct packed {
      logic signed [VAL_W-1:0] smallest;
      logic signed [VAL_W-1:0] largest;
      logic                    stretch;
   } range_type;

endpackage

>>> rtl/core/ptmm_lane.sv
// ----------------------------------------------------------------------------
// ptmm_lane
// One channel converter: clamp-and-scale or min-max stretch to a byte, the
// stretch quotient found by an 8-step restoring divider.
// ----------------------------------------------------------------------------
module ptmm_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ptmm_pkg::VAL_W-1:0]   value,
   input  ptmm_pkg::range_type                 rng,
   output logic [ptmm_pkg::BYTE_W-1:0]         pix_byte,
   output logic                                done
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        div_ff, div_in;
   logic [2:0]  step_ff, step_in;
   logic [33:0] rem_ff, rem_in;
   logic [24:0] den_ff, den_in;
   logic [7:0]  quo_ff, quo_in;

   logic signed [24:0] t_val;
   logic signed [24:0] span;
   logic [25:0]        prod;
   logic [33:0]        numer;
   logic [34:0]        den_sh;
   logic [34:0]        trial;

   // Offsets from the frame minimum and the clamp-path product.
   always_comb begin
      t_val  = {value[23], value} - {rng.smallest[23], rng.smallest};
      span   = {rng.largest[23], rng.largest} - {rng.smallest[23], rng.smallest};
      prod   = ({9'd0, value[16:0]} << 8) - {9'd0, value[16:0]} + 26'd32768;
      numer  = ({10'd0, t_val[23:0]} << 9) - ({10'd0, t_val[23:0]} << 1)
               + {10'd0, span[23:0]};
      den_sh = {10'd0, den_ff} << step_ff;
      trial  = {1'b0, rem_ff} - den_sh;
   end

   // Classification at start, then one quotient bit per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd7;
         div_in  = 1'b0;
         rem_in  = numer;
         den_in  = {span[23:0], 1'b0};
         quo_in  = 8'd0;
         if (rng.stretch) begin
            if (span <= 25'sd0 || t_val <= 25'sd0) begin
               quo_in = 8'd0;
            end else if (t_val >= span) begin
               quo_in = 8'd255;
            end else begin
               div_in = 1'b1;
            end
         end else begin
            if (value <= 24'sd0) begin
               quo_in = 8'd0;
            end else if (value >= ptmm_pkg::Q_ONE) begin
               quo_in = 8'd255;
            end else begin
               quo_in = prod[23:16];
            end
         end
      end else if (busy_ff) begin
         if (div_ff && !trial[34]) begin
            rem_in          = trial[33:0];
            quo_in[step_ff] = 1'b1;
         end
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff  <= div_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign pix_byte = quo_ff;
   assign done     = done_ff;

endmodule

>>> rtl/core/ptmm_posdiv.sv
// ----------------------------------------------------------------------------
// ptmm_posdiv
// Restoring divider that splits a linear read position into row and column,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptmm_posdiv #(
   parameter int DIVIDEND_W = 17,
   parameter int DIVISOR_W  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder,
   output logic                  done
);

   localparam int CNW = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNW-1:0]        cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;

   // One shift-and-subtract step.
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, div_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNW'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

>>> rtl/core/planar_tensor_minmax_to_bgr8_unit.sv
// ----------------------------------------------------------------------------
// planar_tensor_minmax_to_bgr8_unit
// Crops an RGB Q8.16 frame into a frame store, tracks its minimum and
// maximum, and reads it back as BGR bytes, stretched or clamped.
// ----------------------------------------------------------------------------
// Pixels stream in at one load per clock while the sequencer is idle and no register
// write is pending. A read transfer's response is produced in order: the frame store
// is read at the accepting edge, the three channel lanes then load, their restoring
// dividers run, the sequencer sees done, and the bytes land in the output register.
// The next request is taken only after the response is staged, so a read is not
// accepted while an earlier one is still in flight, and a stalled response holds the
// sequencer until it is taken. After any register write the unit splits the read
// position into row and column, with request transfers stalled. The frame store is
// not cleared at reset.
module planar_tensor_minmax_to_bgr8_unit #(
   parameter int MAX_WIDTH  = ptmm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ptmm_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_type,
   input  logic signed [ptmm_pkg::VAL_W-1:0]        req_red_value,
   input  logic signed [ptmm_pkg::VAL_W-1:0]        req_green_value,
   input  logic signed [ptmm_pkg::VAL_W-1:0]        req_blue_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [ptmm_pkg::BYTE_W-1:0]              rsp_blue_byte,
   output logic [ptmm_pkg::BYTE_W-1:0]              rsp_green_byte,
   output logic [ptmm_pkg::BYTE_W-1:0]              rsp_red_byte,
   output logic                                     rsp_last_pixel,
   output logic                                     rsp_status,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [ptmm_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [ptmm_pkg::CSR_DATA_W-1:0]          csr_data
);

`include "planar_tensor_minmax_to_bgr8_unit_defines.svh"

   localparam int LCW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int LRB   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW    = LCW + 1;
   localparam int HW    = LRB + 1;
   localparam int SZA   = (WW > HW) ? WW : HW;
   localparam int SZW   = (SZA > ptmm_pkg::CSR_DATA_W) ? SZA : ptmm_pkg::CSR_DATA_W;
   localparam int RP_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int CMW   = (RP_W > SZW) ? RP_W : SZW;
   localparam int AW    = LCW + LRB;
   localparam int DEPTH = 2 ** AW;

   // Configuration registers.
   logic [ptmm_pkg::CSR_DATA_W-1:0] tw_ff, th_ff, ccol_ff, crow_ff;
   logic                            norm_ff;
   logic                            csr_wr;

   // Frame state.
   logic signed [ptmm_pkg::VAL_W-1:0] min_ff, min_in;
   logic signed [ptmm_pkg::VAL_W-1:0] max_ff, max_in;
   logic [LCW-1:0]  ld_col_ff, ld_col_in;
   logic [LRB-1:0]  ld_row_ff, ld_row_in;
   logic            ready_ff, ready_in;
   logic [RP_W-1:0] rp_ff, rp_in;
   logic [RP_W-1:0] rd_row_ff, rd_row_in;
   logic [LCW-1:0]  rd_col_ff, rd_col_in;
   logic            sync_pend_ff;

   // Read bookkeeping.
   logic rd_ok_ff, rd_last_ff, stretch_ff;

   // Sequencer.
   ptmm_pkg::state_type state_ff, state_in;
   logic load_acc, read_acc, lane_start, pd_start, out_load;

   // Output register.
   logic                        rsp_valid_ff;
   logic [ptmm_pkg::BYTE_W-1:0] blue_ff, green_ff, red_ff;
   logic                        last_ff, status_ff;

   // Effective geometry.
   logic [SZW-1:0] eff_w, eff_h, cc, cr, tw_x, th_x, ccol_x, crow_x;

   // Frame store.
   ptmm_pkg::pixel_type store_mem [DEPTH];
   ptmm_pkg::pixel_type rdata_ff;
   logic                mem_wr;
   logic [AW-1:0]       mem_waddr, mem_raddr;

   // Lanes and position divider.
   ptmm_pkg::range_type         rng;
   logic [2:0]                  lane_done;
   logic [ptmm_pkg::BYTE_W-1:0] lane_byte [3];
   logic [RP_W-1:0]             pd_quo;
   logic [SZW-1:0]              pd_rem;
   logic                        pd_done;

   // Load-path temporaries.
   logic [LCW-1:0]  base_col;
   logic [LRB-1:0]  base_row;
   logic [SZW-1:0]  col_inc, row_inc;
   logic            in_crop;
   logic signed [ptmm_pkg::VAL_W-1:0] base_min, base_max, pix_min, pix_max;

   // Read-path temporaries.
   logic rd_ok, rd_last, col_wrap;

   // Geometry: sizes saturated to the store, crops limited to the sizes.
   always_comb begin
      tw_x   = SZW'(tw_ff);
      th_x   = SZW'(th_ff);
      ccol_x = SZW'(ccol_ff);
      crow_x = SZW'(crow_ff);
      if (tw_x == '0) eff_w = SZW'(1);
      else if (tw_x > SZW'(MAX_WIDTH)) eff_w = SZW'(MAX_WIDTH);
      else eff_w = tw_x;
      if (th_x == '0) eff_h = SZW'(1);
      else if (th_x > SZW'(MAX_HEIGHT)) eff_h = SZW'(MAX_HEIGHT);
      else eff_h = th_x;
      cc = (ccol_x < eff_w) ? ccol_x : eff_w;
      cr = (crow_x < eff_h) ? crow_x : eff_h;
   end

   // Configuration writes.
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff   <= ptmm_pkg::RST_SIZE;
         th_ff   <= ptmm_pkg::RST_SIZE;
         ccol_ff <= ptmm_pkg::RST_SIZE;
         crow_ff <= ptmm_pkg::RST_SIZE;
         norm_ff <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_index)
            ptmm_pkg::CSR_TENSOR_WIDTH:  tw_ff   <= csr_data;
            ptmm_pkg::CSR_TENSOR_HEIGHT: th_ff   <= csr_data;
            ptmm_pkg::CSR_CROP_COLUMNS:  ccol_ff <= csr_data;
            ptmm_pkg::CSR_CROP_ROWS:     crow_ff <= csr_data;
            ptmm_pkg::CSR_NORM_ENABLE:   norm_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptmm_pkg::ST_IDLE: begin
            if (pd_start) state_in = ptmm_pkg::ST_SYNC;
            else if (read_acc) state_in = ptmm_pkg::ST_FETCH;
         end
         ptmm_pkg::ST_FETCH: state_in = ptmm_pkg::ST_CONV;
         ptmm_pkg::ST_CONV: begin
            if (lane_done[0]) state_in = ptmm_pkg::ST_OUT;
         end
         ptmm_pkg::ST_OUT: begin
            if (out_load) state_in = ptmm_pkg::ST_IDLE;
         end
         ptmm_pkg::ST_SYNC: begin
            if (pd_done) state_in = ptmm_pkg::ST_IDLE;
         end
         default: state_in = ptmm_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall  = (state_ff != ptmm_pkg::ST_IDLE) || sync_pend_ff;
      load_acc   = req_valid && !req_stall && (req_type == ptmm_pkg::REQ_LOAD);
      read_acc   = req_valid && !req_stall && (req_type == ptmm_pkg::REQ_READ);
      lane_start = (state_ff == ptmm_pkg::ST_FETCH);
      pd_start   = (state_ff == ptmm_pkg::ST_IDLE) && sync_pend_ff;
      out_load   = (state_ff == ptmm_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   // Load path: restart after a complete frame, store cropped pixels,
   // fold the pixel into the running range and step the raster counters.
   always_comb begin
      base_col = ready_ff ? '0 : ld_col_ff;
      base_row = ready_ff ? '0 : ld_row_ff;
      base_min = ready_ff ? ptmm_pkg::VAL_MAX : min_ff;
      base_max = ready_ff ? ptmm_pkg::VAL_MIN : max_ff;
      in_crop  = (SZW'(base_col) < cc) && (SZW'(base_row) < cr);
      pix_min  = req_red_value;
      if (req_green_value < pix_min) pix_min = req_green_value;
      if (req_blue_value < pix_min) pix_min = req_blue_value;
      pix_max  = req_red_value;
      if (req_green_value > pix_max) pix_max = req_green_value;
      if (req_blue_value > pix_max) pix_max = req_blue_value;
      col_inc  = SZW'(base_col) + SZW'(1);
      row_inc  = SZW'(base_row) + SZW'(1);
      mem_wr    = load_acc && in_crop;
      mem_waddr = {base_row, base_col};
   end

   // Read path: row and column are kept alongside the linear position.
   always_comb begin
      rd_ok    = ready_ff && (cc != '0) && (CMW'(rd_row_ff) < CMW'(cr));
      col_wrap = (SZW'(rd_col_ff) + SZW'(1)) == cc;
      rd_last  = col_wrap && ((CMW'(rd_row_ff) + CMW'(1)) == CMW'(cr));
      mem_raddr = {rd_row_ff[LRB-1:0], rd_col_ff};
   end

   // Frame state next values.
   always_comb begin
      min_in    = min_ff;
      max_in    = max_ff;
      ld_col_in = ld_col_ff;
      ld_row_in = ld_row_ff;
      ready_in  = ready_ff;
      rp_in     = rp_ff;
      rd_row_in = rd_row_ff;
      rd_col_in = rd_col_ff;
      if (load_acc) begin
         min_in    = base_min;
         max_in    = base_max;
         ready_in  = 1'b0;
         if (ready_ff) begin
            rp_in     = '0;
            rd_row_in = '0;
            rd_col_in = '0;
         end
         if (in_crop) begin
            if (pix_min < base_min) min_in = pix_min;
            if (pix_max > base_max) max_in = pix_max;
         end
         ld_col_in = LCW'(col_inc);
         ld_row_in = base_row;
         if (col_inc >= eff_w) begin
            ld_col_in = '0;
            ld_row_in = LRB'(row_inc);
            if (row_inc >= eff_h) begin
               ld_row_in = '0;
               ready_in  = 1'b1;
               rp_in     = '0;
               rd_row_in = '0;
               rd_col_in = '0;
            end
         end
      end else if (read_acc && rd_ok) begin
         rp_in = rp_ff + RP_W'(1);
         if (col_wrap) begin
            rd_col_in = '0;
            rd_row_in = rd_row_ff + RP_W'(1);
         end else begin
            rd_col_in = rd_col_ff + LCW'(1);
         end
      end else if (pd_done) begin
         rd_row_in = pd_quo;
         rd_col_in = LCW'(pd_rem);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptmm_pkg::ST_IDLE;
         min_ff       <= ptmm_pkg::VAL_MAX;
         max_ff       <= ptmm_pkg::VAL_MIN;
         ld_col_ff    <= '0;
         ld_row_ff    <= '0;
         ready_ff     <= 1'b0;
         rp_ff        <= '0;
         rd_row_ff    <= '0;
         rd_col_ff    <= '0;
         sync_pend_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         ld_col_ff <= ld_col_in;
         ld_row_ff <= ld_row_in;
         ready_ff  <= ready_in;
         rp_ff     <= rp_in;
         rd_row_ff <= rd_row_in;
         rd_col_ff <= rd_col_in;
         if (csr_wr) sync_pend_ff <= 1'b1;
         else if (pd_start) sync_pend_ff <= 1'b0;
      end
   end

   // Per-read flags captured at the request transfer.
   always_ff @(posedge clock) begin
      if (read_acc) begin
         rd_ok_ff   <= rd_ok;
         rd_last_ff <= rd_last;
         stretch_ff <= norm_ff && ((min_ff < 24'sd0) || (max_ff > ptmm_pkg::Q_ONE));
      end
   end

   // Frame store, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         store_mem[mem_waddr] <= '{red: req_red_value, green: req_green_value,
                                   blue: req_blue_value};
      end
      if (read_acc) begin
         rdata_ff <= store_mem[mem_raddr];
      end
   end

   // Three channel lanes.
   always_comb begin
      rng.smallest = min_ff;
      rng.largest  = max_ff;
      rng.stretch  = stretch_ff;
   end

   ptmm_lane u_lane_blue (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .value    (rdata_ff.blue),
      .rng      (rng),
      .pix_byte (lane_byte[0]),
      .done     (lane_done[0])
   );

   ptmm_lane u_lane_green (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .value    (rdata_ff.green),
      .rng      (rng),
      .pix_byte (lane_byte[1]),
      .done     (lane_done[1])
   );

   ptmm_lane u_lane_red (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .value    (rdata_ff.red),
      .rng      (rng),
      .pix_byte (lane_byte[2]),
      .done     (lane_done[2])
   );

   // Read position to row and column after a register change.
   ptmm_posdiv #(
      .DIVIDEND_W (RP_W),
      .DIVISOR_W  (SZW)
   ) u_posdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (pd_start),
      .dividend  (rp_ff),
      .divisor   (cc),
      .quotient  (pd_quo),
      .remainder (pd_rem),
      .done      (pd_done)
   );

   // Merge stage: lane bytes and read flags into the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         blue_ff   <= rd_ok_ff ? lane_byte[0] : '0;
         green_ff  <= rd_ok_ff ? lane_byte[1] : '0;
         red_ff    <= rd_ok_ff ? lane_byte[2] : '0;
         last_ff   <= rd_ok_ff && rd_last_ff;
         status_ff <= !rd_ok_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blue_byte  = blue_ff;
   assign rsp_green_byte = green_ff;
   assign rsp_red_byte   = red_ff;
   assign rsp_last_pixel = last_ff;
   assign rsp_status     = status_ff;

   // The lanes run in lockstep, so one done stands for all three.
   `PTMM_ASSERT_IMP(a_lanes_lockstep, clock, reset, lane_done[0], lane_done[1] && lane_done[2])
   // Requests are held off whenever the sequencer is busy.
   `PTMM_ASSERT_IMP(a_busy_stalls, clock, reset, state_ff != ptmm_pkg::ST_IDLE, req_stall)
   // A response without a pixel carries zero bytes and no last mark.
   `PTMM_ASSERT_IMP(a_empty_read_zero, clock, reset, rsp_valid && rsp_status, rsp_blue_byte == 8'd0 && rsp_green_byte == 8'd0 && rsp_red_byte == 8'd0 && !rsp_last_pixel)
   // Starting the position split consumes the pending request.
   `PTMM_ASSERT_NXT(a_sync_consumed, clock, reset, pd_start && !csr_wr, !sync_pend_ff && state_ff == ptmm_pkg::ST_SYNC)

endmodule
